/* rtl/isc_pkg.sv */
// Shared types and constants for the indexed sequence store.
`timescale 1ns / 1ps
package isc_pkg;
	localparam int CAPACITY_DEF = 32;
	localparam int ACT_W = 3;
	localparam int POS_W = 6;
	localparam int DATA_W = 32;
	localparam int OCC_W = 6;
	localparam int IN_TDATA_W = 48;
	localparam int OUT_TDATA_W = 40;

	localparam logic [ACT_W-1:0] ACT_LENGTH = 3'd0;
	localparam logic [ACT_W-1:0] ACT_INSERT = 3'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REMOVE = 3'd3;
	localparam logic [ACT_W-1:0] ACT_DUMP = 3'd4;

	localparam logic [DATA_W-1:0] MISSING = '1;

	typedef struct packed {
		logic ins;
		logic rem;
		logic [POS_W-1:0] pos;
		logic [DATA_W-1:0] value;
	} cell_ctrl_t;
endpackage

/* rtl/isc_cell.sv */
// One storage cell of the chain: holds a slot and shifts to or from its neighbors.
`timescale 1ns / 1ps
module isc_cell #(
	parameter int CELL_IDX = 0
) (
	input  logic clk,
	input  isc_pkg::cell_ctrl_t ctrl,
	input  logic [isc_pkg::DATA_W-1:0] left_data,
	input  logic [isc_pkg::DATA_W-1:0] right_data,
	output logic [isc_pkg::DATA_W-1:0] data
);
	import isc_pkg::*;

	localparam logic [POS_W-1:0] MY_IDX = POS_W'(CELL_IDX);

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (MY_IDX > ctrl.pos) begin
				data_q <= left_data;
			end else if (MY_IDX == ctrl.pos) begin
				data_q <= ctrl.value;
			end
		end else if (ctrl.rem) begin
			if (MY_IDX >= ctrl.pos) begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;
endmodule

/* rtl/isc_chain.sv */
// Row of storage cells with a single read port selected by index.
`timescale 1ns / 1ps
module isc_chain #(
	parameter int CAPACITY = isc_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  isc_pkg::cell_ctrl_t ctrl,
	input  logic [$clog2(CAPACITY)-1:0] rd_idx,
	output logic [isc_pkg::DATA_W-1:0] rd_data
);
	import isc_pkg::*;

	logic [DATA_W-1:0] cell_data [CAPACITY];

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_W-1:0] left_in;
		logic [DATA_W-1:0] right_in;
		if (i == 0) begin : g_first
			assign left_in = ctrl.value;
		end else begin : g_mid_l
			assign left_in = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_in = cell_data[i];
		end else begin : g_mid_r
			assign right_in = cell_data[i+1];
		end
		isc_cell #(
			.CELL_IDX(i)
		) u_cell (
			.clk(clk),
			.ctrl(ctrl),
			.left_data(left_in),
			.right_data(right_in),
			.data(cell_data[i])
		);
	end

	assign rd_data = cell_data[rd_idx];
endmodule

/* rtl/indexed_sequence_store_top.sv */
// Top level of the indexed sequence store: command decode, dump sequencer and output register.
//
// Commands arrive on the s_ stream, one per transfer; results leave on the m_ stream.
// s_tdata holds action, position and item_value; m_tdata holds data_out and occupancy,
// m_tuser carries found and m_tlast marks the final result of a command.
// Length and query each give one result, which is registered in the output register
// on the command transfer; insert and remove give no result.
// Dump of a non-empty store enters the dump state and then registers one stored element per cycle
// while the output register is free; an empty store gives a single not-found result. The elements are read
// through the single read port of the cell chain, and no command is accepted until the last element has been
// registered.
// Insert and remove shift the cells from the position upward in parallel.
// A new command is accepted while a result is still waiting, as long as the output
// register is freed in the same cycle.
// When the receiver stalls, the output register holds its result and the block stops
// accepting commands or advancing a dump.
// Reset empties the store and clears the output valid; slot contents are not cleared.
`timescale 1ns / 1ps
module indexed_sequence_store_top #(
	parameter int CAPACITY = isc_pkg::CAPACITY_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// action [2:0], position [8:3], item_value [40:9], zero fill above.
	input  logic [isc_pkg::IN_TDATA_W-1:0] s_tdata,
	output logic m_tvalid,
	input  logic m_tready,
	// data_out [31:0], occupancy [37:32], zero fill above.
	output logic [isc_pkg::OUT_TDATA_W-1:0] m_tdata,
	// found [0].
	output logic m_tuser,
	output logic m_tlast
);
	import isc_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int CMP_W = POS_W + 1;
	localparam logic [CMP_W-1:0] CAP_CMP = CMP_W'(CAPACITY);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_DUMP = 2'b10
	} state_t;

	state_t state_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	logic m_tvalid_q;
	logic [DATA_W-1:0] data_q;
	logic [OCC_W-1:0] occ_q;
	logic found_q;
	logic last_q;

	logic [ACT_W-1:0] action;
	logic [POS_W-1:0] position;
	logic [DATA_W-1:0] item_value;
	logic out_free;
	logic accept;
	logic out_load;
	logic [CMP_W-1:0] pos_cmp;
	logic [CMP_W-1:0] cnt_cmp;
	logic in_range;
	logic not_full;
	logic dump_last;
	cell_ctrl_t ctrl;
	logic [IDX_W-1:0] rd_idx;
	logic [DATA_W-1:0] rd_data;

	assign action = s_tdata[ACT_W-1:0];
	assign position = s_tdata[ACT_W+POS_W-1:ACT_W];
	assign item_value = s_tdata[ACT_W+POS_W+DATA_W-1:ACT_W+POS_W];

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE) && out_free;
	assign accept = s_tvalid && s_tready;

	assign out_load = ((state_q == ST_DUMP) && out_free) ||
		((state_q == ST_IDLE) && accept &&
		((action == ACT_LENGTH) || (action == ACT_QUERY) ||
		((action == ACT_DUMP) && (count_q == '0))));

	assign pos_cmp = CMP_W'(position);
	assign cnt_cmp = CMP_W'(count_q);
	assign in_range = pos_cmp < cnt_cmp;
	assign not_full = cnt_cmp < CAP_CMP;
	assign dump_last = (CMP_W'(idx_q) + CMP_W'(1)) == cnt_cmp;

	always_comb begin
		ctrl.ins = accept && (action == ACT_INSERT) && not_full;
		ctrl.rem = accept && (action == ACT_REMOVE) && in_range;
		ctrl.pos = (ctrl.ins && !in_range) ? POS_W'(count_q) : position;
		ctrl.value = item_value;
	end

	assign rd_idx = (state_q == ST_DUMP) ? idx_q : position[IDX_W-1:0];

	isc_chain #(
		.CAPACITY(CAPACITY)
	) u_chain (
		.clk(clk),
		.ctrl(ctrl),
		.rd_idx(rd_idx),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			m_tvalid_q <= out_load || (m_tvalid_q && !m_tready);
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (action)
							ACT_LENGTH, ACT_QUERY: begin
							end
							ACT_INSERT: begin
								if (not_full) begin
									count_q <= count_q + CNT_W'(1);
								end
							end
							ACT_REMOVE: begin
								if (in_range) begin
									count_q <= count_q - CNT_W'(1);
								end
							end
							ACT_DUMP: begin
								if (count_q != '0) begin
									state_q <= ST_DUMP;
									idx_q <= '0;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_DUMP: begin
					if (out_free) begin
						if (dump_last) begin
							state_q <= ST_IDLE;
						end else begin
							idx_q <= idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DUMP) begin
			if (out_free) begin
				data_q <= rd_data;
				found_q <= 1'b1;
				last_q <= dump_last;
				occ_q <= OCC_W'(count_q);
			end
		end else if (accept) begin
			occ_q <= OCC_W'(count_q);
			last_q <= 1'b1;
			if (action == ACT_LENGTH) begin
				data_q <= DATA_W'(count_q);
				found_q <= 1'b1;
			end else if (action == ACT_QUERY && in_range) begin
				data_q <= rd_data;
				found_q <= 1'b1;
			end else begin
				data_q <= MISSING;
				found_q <= 1'b0;
			end
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = {{(OUT_TDATA_W - DATA_W - OCC_W){1'b0}}, occ_q, data_q};
	assign m_tuser = found_q;
	assign m_tlast = last_q;

`ifndef SYNTHESIS
	a_no_accept_in_dump: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> !s_tready)
		else $error("command accepted during dump");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(count_q) <= CAP_CMP)
		else $error("count above capacity");

	a_dump_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DUMP) |-> (CMP_W'(idx_q) < cnt_cmp))
		else $error("dump index past count");

	a_insert_grows: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.ins |=> (count_q == $past(count_q) + CNT_W'(1)))
		else $error("insert did not grow count");
`endif
endmodule
